### hdl/audio_transition_length_demodulator_core_assert.svh
// assertion macros used by the checker file
`ifndef AUDIO_TRANSITION_LENGTH_DEMODULATOR_CORE_ASSERT_SVH
`define AUDIO_TRANSITION_LENGTH_DEMODULATOR_CORE_ASSERT_SVH

// checked only while out of reset
`define ATLD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define ATLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/atld_pkg.sv
package atld_pkg;

  localparam int SampleW  = 10;
  localparam int ActW     = 16;
  localparam int BltW     = 5;
  localparam int WinW     = 7;
  localparam int SpanW    = 7;
  localparam int ByteW    = 8;
  localparam int BitCntW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [SpanW-1:0] SPAN_LIMIT = 7'd100;

  localparam logic [ActW-1:0] ACT_THR_RST = 16'd64;
  localparam logic [BltW-1:0] BLT_RST     = 5'd8;
  localparam logic [WinW-1:0] WIN_RST     = 7'd4;

  localparam logic [CfgIdxW-1:0] CFG_ACT_THR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIT_LEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIN_LEN = 2'd2;

  typedef enum logic [1:0] {
    TONE_NONE = 2'd0,
    TONE_LOW  = 2'd1,
    TONE_HIGH = 2'd2
  } tone_t;

  // window stage towards the symbol stage
  typedef struct packed {
    logic            close;
    logic [ActW-1:0] activity;
  } win_t;

  // symbol stage towards the result register
  typedef struct packed {
    logic             emit;
    logic             flush;
    logic [ByteW-1:0] data_byte;
  } res_t;

endpackage

### hdl/audio_transition_length_demodulator_core.sv
// an accepted sample is held in the input register, and its result then in the result register
// throughput: one sample per cycle; the input register and the result
// register each hold one item, so the input stalls only while a result is stalled
// reset (synchronous, rst_n low) empties both registers, clears the window and
// bit state and loads the register defaults (threshold 64, bit length 8, window 4)
module audio_transition_length_demodulator_core
  import atld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SampleW-1:0]  in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ByteW-1:0]    out_data_byte,
  output logic                out_flush,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [ActW-1:0] act_thr_r;
  logic [BltW-1:0] bit_len_r;
  logic [WinW-1:0] win_len_r;

  logic               s1_valid_r;
  logic [SampleW-1:0] s1_sample_r;
  logic               out_valid_r;
  logic [ByteW-1:0]   out_byte_r;
  logic               out_flush_r;

  logic advance;
  logic process;
  logic in_accept;
  win_t win;
  res_t res;

  assign advance   = !out_valid_r || !out_stall;
  assign process   = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_thr_r <= ACT_THR_RST;
      bit_len_r <= BLT_RST;
      win_len_r <= WIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ACT_THR: act_thr_r <= cfg_wdata[ActW-1:0];
        CFG_BIT_LEN: bit_len_r <= cfg_wdata[BltW-1:0];
        CFG_WIN_LEN: win_len_r <= cfg_wdata[WinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
    end
  end

  atld_window u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (process),
    .sample         (s1_sample_r),
    .window_samples (win_len_r),
    .win            (win)
  );

  atld_symbol u_symbol (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (process && win.close),
    .activity    (win.activity),
    .act_thr     (act_thr_r),
    .bit_len_thr (bit_len_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= process && win.close && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= res.data_byte;
      out_flush_r <= res.flush;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_flush     = out_flush_r;

endmodule

### hdl/atld_window.sv
module atld_window
  import atld_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [SampleW-1:0] sample,
  input  logic [WinW-1:0]    window_samples,
  output win_t               win
);

  logic [SampleW-1:0] prev_r;
  logic [ActW-1:0]    sum_r;
  logic [WinW-1:0]    wcnt_r;

  logic [SampleW-1:0] delta;
  logic [ActW:0]      sum_wide;
  logic [ActW-1:0]    sum_sat;
  logic [WinW-1:0]    wcnt_inc;

  always_comb begin
    delta    = (sample > prev_r) ? (sample - prev_r) : (prev_r - sample);
    sum_wide = {1'b0, sum_r} + {{(ActW+1-SampleW){1'b0}}, delta};
    sum_sat  = sum_wide[ActW] ? {ActW{1'b1}} : sum_wide[ActW-1:0];
    wcnt_inc = wcnt_r + 1'b1;
    win.close    = (wcnt_inc == '0) || (wcnt_inc >= window_samples);
    win.activity = sum_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
      wcnt_r <= '0;
    end else if (step) begin
      prev_r <= sample;
      if (win.close) begin
        sum_r  <= '0;
        wcnt_r <= '0;
      end else begin
        sum_r  <= sum_sat;
        wcnt_r <= wcnt_inc;
      end
    end
  end

endmodule

### hdl/atld_symbol.sv
module atld_symbol
  import atld_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [ActW-1:0] activity,
  input  logic [ActW-1:0] act_thr,
  input  logic [BltW-1:0] bit_len_thr,
  output res_t            res
);

  logic [SpanW-1:0]   span_r,  span_nxt;
  tone_t              tone_r,  tone_nxt;
  logic [BitCntW-1:0] bits_r,  bits_nxt;
  logic [ByteW-1:0]   shift_r, shift_nxt;

  logic [SpanW-1:0] span_inc;
  logic             is_high;
  logic             silence;
  tone_t            tone_new;

  always_comb begin
    span_inc  = (span_r < SPAN_LIMIT) ? (span_r + 1'b1) : span_r;
    is_high   = (activity >= act_thr);
    silence   = !is_high && (span_inc > {bit_len_thr, 2'b00});
    tone_new  = is_high ? TONE_HIGH : TONE_LOW;
    span_nxt  = span_inc;
    tone_nxt  = tone_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    res       = '0;
    if (silence) begin
      tone_nxt  = TONE_NONE;
      bits_nxt  = '0;
      shift_nxt = '0;
      res.emit  = 1'b1;
      res.flush = 1'b1;
    end else if (tone_new != tone_r) begin
      if (tone_r != TONE_NONE) begin
        // lsb first: new bit enters at the top
        shift_nxt = {(span_inc >= {2'b00, bit_len_thr}), shift_r[ByteW-1:1]};
        bits_nxt  = bits_r + 1'b1;
        if (bits_nxt == '0) begin
          res.emit      = 1'b1;
          res.data_byte = shift_nxt;
        end
      end
      tone_nxt = tone_new;
      span_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r  <= '0;
      tone_r  <= TONE_NONE;
      bits_r  <= '0;
      shift_r <= '0;
    end else if (step) begin
      span_r  <= span_nxt;
      tone_r  <= tone_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

### hdl/atld_checker.sv
`include "audio_transition_length_demodulator_core_assert.svh"

module atld_checker
  import atld_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ByteW-1:0] out_data_byte,
  input logic             out_flush
);

  `ATLD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_flush), "stalled result changed")
  `ATLD_ASSERT(a_flush_zero, clk, rst_n, out_valid && out_flush |-> out_data_byte == '0, "flush result carries a byte")
  `ATLD_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without a blocked result")
  `ATLD_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind audio_transition_length_demodulator_core atld_checker u_atld_checker (.*);
